// ----- sv/gsa_pkg.sv -----
// Shared constants and types for the sigmoid-form GELU pipeline.
`default_nettype none
package gsa_pkg;

  // Exponential segment selected from the scaled argument u.
  typedef enum logic [2:0] {
    SEG_LIN_LO,
    SEG_CUB_LO,
    SEG_QUART,
    SEG_CUB_HI,
    SEG_LIN_HI
  } gsa_seg_t;

  // Q16.16 constants.
  localparam logic signed [18:0] K_SLOPE  = 19'sd111542;
  localparam logic signed [31:0] Q_ONE    = 32'sd65536;
  localparam logic signed [31:0] U_NEG5   = -32'sd327680;
  localparam logic signed [31:0] U_NEG2   = -32'sd131072;
  localparam logic signed [31:0] U_POS2   = 32'sd131072;
  localparam logic signed [31:0] U_POS5   = 32'sd327680;
  localparam logic signed [32:0] T_CENTER = 33'sd229376;
  localparam logic signed [32:0] LO_SHIFT = 33'sd655360;
  localparam logic signed [32:0] HI_SHIFT = 33'sd327680;
  localparam logic signed [39:0] HI_BASE  = 40'sd6553600;

  localparam logic signed [23:0] LIN_LO_C = 24'sd66;
  localparam logic signed [23:0] LIN_HI_C = 24'sd3276800;

  localparam logic signed [23:0] CL_C0 = 24'sd1979;
  localparam logic signed [23:0] CL_C1 = 24'sd1860;
  localparam logic signed [23:0] CL_C2 = 24'sd911;
  localparam logic signed [23:0] CL_C3 = 24'sd297;

  localparam logic signed [23:0] CH_C0 = 24'sd1077716;
  localparam logic signed [23:0] CH_C1 = 24'sd1077716;
  localparam logic signed [23:0] CH_C2 = 24'sd538858;
  localparam logic signed [23:0] CH_C3 = 24'sd179619;

  localparam logic signed [23:0] QT_C2 = 24'sd32768;
  localparam logic signed [23:0] QT_C3 = 24'sd10923;
  localparam logic signed [23:0] QT_C4 = 24'sd2731;

  // Reciprocal in Q2.16.
  localparam int unsigned DIV_STEPS = 17;
  localparam logic signed [17:0] R_MAX = 18'sd131071;
  localparam logic signed [17:0] R_MIN = -18'sd131072;

endpackage
`default_nettype wire

// ----- sv/gsa_if.sv -----
// Valid/ready stream interfaces for the GELU input and result channels.
`default_nettype none
interface gsa_in_if #(parameter int ELEM_WIDTH = 8);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] x_in;
  logic                         in_last;
  modport source (output valid, output x_in, output in_last, input ready);
  modport sink   (input valid, input x_in, input in_last, output ready);
endinterface

interface gsa_out_if #(parameter int ELEM_WIDTH = 8);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] y_out;
  logic                         out_last;
  modport source (output valid, output y_out, output out_last, input ready);
  modport sink   (input valid, input y_out, input out_last, output ready);
endinterface
`default_nettype wire

// ----- sv/gelu_sigmoid_approx_top.sv -----
// Streaming GELU, y = x / (1 + e(-1.702x)), with a piecewise exponential.
// An accepted input beat passes through stages 1 to 5, the divider entries, the multiply and the output register.
// Throughput: one beat per cycle; the pipeline advances as one unit and holds on stall.
// The 17 stages of the restoring reciprocal divider set the depth of the pipeline.
// Reset (synchronous, active low) clears every stage valid bit; payload is not reset.
`default_nettype none
module gelu_sigmoid_approx_top
  import gsa_pkg::*;
#(
  parameter int ELEM_WIDTH = 8
) (
  input  wire             clk,
  input  wire             rst_n,
  gsa_in_if.sink          in_ch,
  gsa_out_if.source       out_ch
);

  // Width of the x * 1.702 product, kept at 33 bits or more so that the
  // overflow check against the Q16.16 range always has bits above bit 31.
  localparam int PW = (ELEM_WIDTH + 19 > 33) ? ELEM_WIDTH + 19 : 33;
  localparam int MW = ELEM_WIDTH + 18;   // width of the x * r product
  localparam int YW = MW - 16;           // width after the Q16 shift

  // The whole pipeline moves when the output register is free or being drained.
  logic en;
  logic o_valid_r;
  assign en          = !o_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: u = -1.702 x, saturated to Q16.16.
  logic                         s1_valid_r;
  logic signed [31:0]           s1_u_r, s1_u_nxt;
  logic signed [ELEM_WIDTH-1:0] s1_x_r;
  logic                         s1_last_r;
  logic signed [PW-1:0]         s1_prod;

  always_comb begin
    s1_prod = -(PW'(in_ch.x_in) * PW'(K_SLOPE));
    if (s1_prod[PW-1:31] != {(PW-31){s1_prod[PW-1]}}) begin
      s1_u_nxt = s1_prod[PW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      s1_u_nxt = s1_prod[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_ch.valid;
    end
    if (en) begin
      s1_u_r    <= s1_u_nxt;
      s1_x_r    <= in_ch.x_in;
      s1_last_r <= in_ch.in_last;
    end
  end

  // Stage 2: segment choice and the local argument of the segment.
  logic                         s2_valid_r;
  gsa_seg_t                     s2_seg_r, s2_seg_nxt;
  logic signed [19:0]           s2_t_r, s2_t_nxt;
  logic signed [32:0]           s2_la_r, s2_la_nxt;
  logic signed [ELEM_WIDTH-1:0] s2_x_r;
  logic                         s2_last_r;
  logic signed [32:0]           s2_u_ext, s2_tw;

  always_comb begin
    s2_u_ext = 33'(s1_u_r);
    if (s1_u_r < U_NEG5) begin
      s2_seg_nxt = SEG_LIN_LO;
    end else if (s1_u_r < U_NEG2) begin
      s2_seg_nxt = SEG_CUB_LO;
    end else if (s1_u_r < U_POS2) begin
      s2_seg_nxt = SEG_QUART;
    end else if (s1_u_r < U_POS5) begin
      s2_seg_nxt = SEG_CUB_HI;
    end else begin
      s2_seg_nxt = SEG_LIN_HI;
    end
    unique case (s2_seg_nxt)
      SEG_CUB_LO: s2_tw = s2_u_ext + T_CENTER;
      SEG_CUB_HI: s2_tw = s2_u_ext - T_CENTER;
      default:    s2_tw = s2_u_ext;
    endcase
    s2_t_nxt  = s2_tw[19:0];
    s2_la_nxt = (s2_seg_nxt == SEG_LIN_LO) ? s2_u_ext + LO_SHIFT : s2_u_ext - HI_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
    if (en) begin
      s2_seg_r  <= s2_seg_nxt;
      s2_t_r    <= s2_t_nxt;
      s2_la_r   <= s2_la_nxt;
      s2_x_r    <= s1_x_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Stage 3: t squared and the linear-segment product.
  logic                         s3_valid_r;
  gsa_seg_t                     s3_seg_r;
  logic signed [19:0]           s3_t_r;
  logic signed [23:0]           s3_t2_r;
  logic signed [39:0]           s3_lin_r;
  logic signed [ELEM_WIDTH-1:0] s3_x_r;
  logic                         s3_last_r;
  logic signed [39:0]           s3_pt;
  logic signed [56:0]           s3_pl;
  logic signed [23:0]           s3_lc;

  always_comb begin
    s3_pt = 40'(s2_t_r) * 40'(s2_t_r);
    s3_lc = (s2_seg_r == SEG_LIN_LO) ? LIN_LO_C : LIN_HI_C;
    s3_pl = 57'(s2_la_r) * 57'(s3_lc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
    if (en) begin
      s3_seg_r  <= s2_seg_r;
      s3_t_r    <= s2_t_r;
      s3_t2_r   <= 24'(s3_pt >>> 16);
      s3_lin_r  <= 40'(s3_pl >>> 16);
      s3_x_r    <= s2_x_r;
      s3_last_r <= s2_last_r;
    end
  end

  // Stage 4: t cubed, t to the fourth, and the first two polynomial terms.
  logic                         s4_valid_r;
  gsa_seg_t                     s4_seg_r;
  logic signed [23:0]           s4_t3_r, s4_t4_r;
  logic signed [31:0]           s4_a1_r, s4_a2_r, s4_a1_nxt;
  logic signed [39:0]           s4_lin_r;
  logic signed [ELEM_WIDTH-1:0] s4_x_r;
  logic                         s4_last_r;
  logic signed [47:0]           s4_p3, s4_p4, s4_p1, s4_p2;
  logic signed [23:0]           s4_c1, s4_c2;

  always_comb begin
    unique case (s3_seg_r)
      SEG_CUB_LO: begin
        s4_c1 = CL_C1;
        s4_c2 = CL_C2;
      end
      SEG_CUB_HI: begin
        s4_c1 = CH_C1;
        s4_c2 = CH_C2;
      end
      default: begin
        s4_c1 = CH_C1;
        s4_c2 = QT_C2;
      end
    endcase
    s4_p3 = 48'(s3_t2_r) * 48'(s3_t_r);
    s4_p4 = 48'(s3_t2_r) * 48'(s3_t2_r);
    s4_p1 = 48'(s4_c1) * 48'(s3_t_r);
    s4_p2 = 48'(s4_c2) * 48'(s3_t2_r);
    s4_a1_nxt = (s3_seg_r == SEG_QUART) ? 32'(s3_t_r) : 32'(s4_p1 >>> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
    if (en) begin
      s4_seg_r  <= s3_seg_r;
      s4_t3_r   <= 24'(s4_p3 >>> 16);
      s4_t4_r   <= 24'(s4_p4 >>> 16);
      s4_a1_r   <= s4_a1_nxt;
      s4_a2_r   <= 32'(s4_p2 >>> 16);
      s4_lin_r  <= s3_lin_r;
      s4_x_r    <= s3_x_r;
      s4_last_r <= s3_last_r;
    end
  end

  // Stage 5: cubic and quartic terms.
  logic                         s5_valid_r;
  gsa_seg_t                     s5_seg_r;
  logic signed [31:0]           s5_a1_r, s5_a2_r, s5_a3_r, s5_a4_r;
  logic signed [39:0]           s5_lin_r;
  logic signed [ELEM_WIDTH-1:0] s5_x_r;
  logic                         s5_last_r;
  logic signed [47:0]           s5_p3, s5_p4;
  logic signed [23:0]           s5_c3;

  always_comb begin
    unique case (s4_seg_r)
      SEG_CUB_LO: s5_c3 = CL_C3;
      SEG_CUB_HI: s5_c3 = CH_C3;
      default:    s5_c3 = QT_C3;
    endcase
    s5_p3 = 48'(s5_c3) * 48'(s4_t3_r);
    s5_p4 = 48'(QT_C4) * 48'(s4_t4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= s4_valid_r;
    end
    if (en) begin
      s5_seg_r  <= s4_seg_r;
      s5_a1_r   <= s4_a1_r;
      s5_a2_r   <= s4_a2_r;
      s5_a3_r   <= 32'(s5_p3 >>> 16);
      s5_a4_r   <= (s4_seg_r == SEG_QUART) ? 32'(s5_p4 >>> 16) : 32'sd0;
      s5_lin_r  <= s4_lin_r;
      s5_x_r    <= s4_x_r;
      s5_last_r <= s4_last_r;
    end
  end

  // Stage 6: sum to e, form d = 1 + e, and split it into sign and magnitude.
  // A magnitude of at most 2^15 (zero included) saturates the reciprocal; one
  // above 2^32 gives a reciprocal of zero.
  logic signed [39:0]           s6_c0, s6_e, s6_d;
  logic [39:0]                  s6_mag;

  always_comb begin
    unique case (s5_seg_r)
      SEG_CUB_LO: s6_c0 = 40'(CL_C0);
      SEG_CUB_HI: s6_c0 = 40'(CH_C0);
      default:    s6_c0 = 40'(Q_ONE);
    endcase
    unique case (s5_seg_r)
      SEG_LIN_LO: s6_e = s5_lin_r;
      SEG_LIN_HI: s6_e = s5_lin_r + HI_BASE;
      default:    s6_e = s6_c0 + 40'(s5_a1_r) + 40'(s5_a2_r) + 40'(s5_a3_r)
                         + 40'(s5_a4_r);
    endcase
    s6_d   = s6_e + 40'(Q_ONE);
    s6_mag = s6_d[39] ? 40'(-s6_d) : 40'(s6_d);
  end

  // Divider pipeline: entry 0 is loaded from stage 6, entry k+1 from entry k.
  logic                         dv_valid_r [0:DIV_STEPS];
  logic [32:0]                  dv_rem_r   [0:DIV_STEPS];
  logic [32:0]                  dv_den_r   [0:DIV_STEPS];
  logic [16:0]                  dv_q_r     [0:DIV_STEPS];
  logic                         dv_neg_r   [0:DIV_STEPS];
  logic                         dv_small_r [0:DIV_STEPS];
  logic                         dv_big_r   [0:DIV_STEPS];
  logic signed [ELEM_WIDTH-1:0] dv_x_r     [0:DIV_STEPS];
  logic                         dv_last_r  [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (en) begin
      dv_valid_r[0] <= s5_valid_r;
    end
    if (en) begin
      dv_rem_r[0]   <= 33'h1_0000_0000;
      dv_den_r[0]   <= s6_mag[32:0];
      dv_q_r[0]     <= '0;
      dv_neg_r[0]   <= s6_d[39];
      dv_small_r[0] <= (s6_mag <= 40'd32768);
      dv_big_r[0]   <= (s6_mag > 40'h1_0000_0000);
      dv_x_r[0]     <= s5_x_r;
      dv_last_r[0]  <= s5_last_r;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int BIT = DIV_STEPS - 1 - k;
    logic [49:0] sub_w;
    logic [49:0] rem_w;
    logic        take;

    always_comb begin
      sub_w = 50'(dv_den_r[k]) << BIT;
      rem_w = 50'(dv_rem_r[k]);
      take  = (rem_w >= sub_w);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_valid_r[k+1] <= dv_valid_r[k];
      end
      if (en) begin
        dv_rem_r[k+1]   <= take ? 33'(rem_w - sub_w) : dv_rem_r[k];
        dv_q_r[k+1]     <= dv_q_r[k] | (17'(take) << BIT);
        dv_den_r[k+1]   <= dv_den_r[k];
        dv_neg_r[k+1]   <= dv_neg_r[k];
        dv_small_r[k+1] <= dv_small_r[k];
        dv_big_r[k+1]   <= dv_big_r[k];
        dv_x_r[k+1]     <= dv_x_r[k];
        dv_last_r[k+1]  <= dv_last_r[k];
      end
    end
  end

  // Multiply stage: pick the signed, saturated reciprocal and form x * r.
  logic                 m_valid_r;
  logic signed [MW-1:0] m_prod_r;
  logic                 m_last_r;
  logic signed [17:0]   m_r;
  logic signed [17:0]   m_qs;

  always_comb begin
    m_qs = 18'(dv_q_r[DIV_STEPS]);
    if (dv_small_r[DIV_STEPS]) begin
      m_r = dv_neg_r[DIV_STEPS] ? R_MIN : R_MAX;
    end else if (dv_big_r[DIV_STEPS]) begin
      m_r = '0;
    end else begin
      m_r = dv_neg_r[DIV_STEPS] ? -m_qs : m_qs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= dv_valid_r[DIV_STEPS];
    end
    if (en) begin
      m_prod_r <= MW'(dv_x_r[DIV_STEPS]) * MW'(m_r);
      m_last_r <= dv_last_r[DIV_STEPS];
    end
  end

  // Output stage: divide by 2^16 toward zero and saturate to the element range.
  logic signed [ELEM_WIDTH-1:0] o_y_r, o_y_nxt;
  logic                         o_last_r;
  logic signed [MW-1:0]         o_adj;
  logic signed [YW-1:0]         o_q;

  always_comb begin
    o_adj = m_prod_r + (m_prod_r[MW-1] ? MW'(65535) : MW'(0));
    o_q   = YW'(o_adj >>> 16);
    if (o_q[YW-1:ELEM_WIDTH-1] != {(YW-ELEM_WIDTH+1){o_q[YW-1]}}) begin
      o_y_nxt = o_q[YW-1] ? {1'b1, {(ELEM_WIDTH-1){1'b0}}} : {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    end else begin
      o_y_nxt = o_q[ELEM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (en) begin
      o_valid_r <= m_valid_r;
    end
    if (en) begin
      o_y_r    <= o_y_nxt;
      o_last_r <= m_last_r;
    end
  end

  assign out_ch.valid    = o_valid_r;
  assign out_ch.y_out    = o_y_r;
  assign out_ch.out_last = o_last_r;

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the streaming sigmoid-form GELU block.
module tb_top;

  localparam int EW = 8;
  localparam int N_RANDOM = 400;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  gsa_in_if  #(.ELEM_WIDTH(EW)) in_ch();
  gsa_out_if #(.ELEM_WIDTH(EW)) out_ch();

  gelu_sigmoid_approx_top #(.ELEM_WIDTH(EW)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  typedef struct packed {
    logic signed [EW-1:0] y;
    logic                 last;
  } gelu_beat_t;

  // One row of the directed table; a result is typed in only where has_y is set.
  typedef struct {
    int   x;
    logic last;
    bit   has_y;
    int   y;
  } dir_row_t;

  gelu_beat_t gelu_expect_q[$];
  int  fail_count = 0;
  bit  stim_done = 1'b0;
  int  idle_cycles = 0;

  // Floor division by 2^16 for a signed product.
  function automatic longint floor16(longint p);
    return p >>> 16;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return floor16(a * b);
  endfunction

  function automatic longint cubic_seg(longint xp, longint c0, longint c1,
                                       longint c2, longint c3);
    longint xp2;
    longint xp3;
    xp2 = qmul(xp, xp);
    xp3 = qmul(xp2, xp);
    return c0 + qmul(c1, xp) + qmul(c2, xp2) + qmul(c3, xp3);
  endfunction

  function automatic longint exp_piecewise(longint u);
    longint u2;
    longint u3;
    longint u4;
    if (u < -5 * 65536) return qmul(66, u + 10 * 65536);
    if (u < -2 * 65536) return cubic_seg(u + 229376, 1979, 1860, 911, 297);
    if (u < 2 * 65536) begin
      u2 = qmul(u, u);
      u3 = qmul(u2, u);
      u4 = qmul(u2, u2);
      return 65536 + u + qmul(32768, u2) + qmul(10923, u3) + qmul(2731, u4);
    end
    if (u < 5 * 65536)
      return cubic_seg(u - 229376, 1077716, 1077716, 538858, 179619);
    return 100 * 65536 + qmul(3276800, u - 5 * 65536);
  endfunction

  function automatic gelu_beat_t gelu_predict(logic signed [EW-1:0] xin, logic lst);
    longint x;
    longint u;
    longint d;
    longint r;
    longint y;
    gelu_beat_t res;
    x = xin;
    u = -(x * 111542);
    if (u > 64'sd2147483647) u = 64'sd2147483647;
    if (u < -64'sd2147483648) u = -64'sd2147483648;
    d = 65536 + exp_piecewise(u);
    if (d == 0) begin
      r = 131071;
    end else begin
      r = (64'sd65536 * 64'sd65536) / d;
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
    end
    y = (x * r) / 65536;
    if (y > (2 ** (EW - 1)) - 1) y = (2 ** (EW - 1)) - 1;
    if (y < -(2 ** (EW - 1))) y = -(2 ** (EW - 1));
    res.y = y[EW-1:0];
    res.last = lst;
    return res;
  endfunction

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.x_in <= '0;
    in_ch.in_last <= 1'b0;
    out_ch.ready <= 1'b0;
  end

  // Sends one beat, after a random gap when gap is set, and waits for it to be taken.
  task automatic send_beat(logic signed [EW-1:0] x, logic lst, bit gap);
    int wait_n;
    wait_n = gap ? $urandom_range(0, 14) : 0;
    repeat (wait_n) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.x_in <= x;
    in_ch.in_last <= lst;
    gelu_expect_q.push_back(gelu_predict(x, lst));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  dir_row_t dir_table[25];

  initial begin
    bit gappy;
    gelu_beat_t e;
    // Extremes, zero, the elements nearest each segment edge (u = -1.702 x), and further mid-range points.
    dir_table = '{
      '{0, 1'b0, 1'b1, 0},
      '{1, 1'b0, 1'b0, 0},
      '{-1, 1'b0, 1'b0, 0},
      '{2, 1'b1, 1'b0, 0},
      '{-2, 1'b0, 1'b0, 0},
      '{3, 1'b0, 1'b0, 0},
      '{-3, 1'b0, 1'b0, 0},
      '{4, 1'b0, 1'b0, 0},
      '{-4, 1'b0, 1'b0, 0},
      '{5, 1'b0, 1'b0, 0},
      '{-5, 1'b0, 1'b0, 0},
      '{6, 1'b0, 1'b0, 0},
      '{-6, 1'b0, 1'b0, 0},
      '{7, 1'b1, 1'b0, 0},
      '{-7, 1'b0, 1'b0, 0},
      '{10, 1'b0, 1'b0, 0},
      '{-10, 1'b0, 1'b0, 0},
      '{127, 1'b0, 1'b1, 127},
      '{-128, 1'b1, 1'b0, 0},
      '{126, 1'b0, 1'b0, 0},
      '{-127, 1'b0, 1'b0, 0},
      '{64, 1'b0, 1'b0, 0},
      '{-64, 1'b1, 1'b0, 0},
      '{85, 1'b0, 1'b0, 0},
      '{-85, 1'b0, 1'b0, 0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_table[i]) begin
      send_beat(dir_table[i].x[EW-1:0], dir_table[i].last, 1'b1);
      if (dir_table[i].has_y) begin
        e = gelu_expect_q[$];
        if (e.y !== dir_table[i].y[EW-1:0]) begin
          $error("table y: expected %0d predicted %0d", dir_table[i].y, e.y);
          fail_count++;
        end
      end
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      // Stretches without gaps alternate with gappy stretches.
      gappy = ((i / 40) % 2) == 1;
      send_beat(EW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), gappy);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off so the pipeline backs up.
  initial begin
    int wait_n;
    @(posedge rst_n);
    repeat (60) @(posedge clk);
    out_ch.ready <= 1'b0;
    repeat (200) @(posedge clk);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (wait_n == 0) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
        out_ch.ready <= 1'b1;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
      end
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    gelu_beat_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (gelu_expect_q.size() == 0) begin
        $error("unexpected result beat y=%0d", out_ch.y_out);
        fail_count++;
      end else begin
        e = gelu_expect_q.pop_front();
        if (out_ch.y_out !== e.y) begin
          $error("y_out: expected %0d actual %0d", e.y, out_ch.y_out);
          fail_count++;
        end
        if (out_ch.out_last !== e.last) begin
          $error("out_last: expected %0d actual %0d", e.last, out_ch.out_last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_n);
    while (!(stim_done && gelu_expect_q.size() == 0) && idle_cycles < STALL_LIMIT)
      @(posedge clk);
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      repeat (50) @(posedge clk);
      if (fail_count == 0 && gelu_expect_q.size() == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
      $finish;
    end
  end
endmodule

// ----- gelu_sigmoid_approx_top.f -----
sv/gsa_pkg.sv
sv/gsa_if.sv
sv/gelu_sigmoid_approx_top.sv
tb/sv/tb_top.sv
